[rtl/mdhfk_pkg.sv]
// Shared types, constants and helper functions for the modified-DH forward
// kinematics block. Depends on nothing; every other file but mdhfk_checker imports it.
`default_nettype none
package mdhfk_pkg;

  localparam logic CMD_GEOM  = 1'b0;
  localparam logic CMD_JOINT = 1'b1;

  localparam logic [3:0] STEP_LINK0  = 4'd0;
  localparam logic [3:0] STEP_LINK1  = 4'd1;
  localparam logic [3:0] STEP_BUBBLE = 4'd2;
  localparam logic [3:0] STEP_POSE0  = 4'd3;
  localparam logic [3:0] STEP_LAST   = 4'd14;

  localparam logic [5:0] CORDIC_FOLD = 6'd4;
  localparam logic [5:0] CORDIC_ITER0 = 6'd5;
  localparam logic [5:0] CORDIC_LAST = 6'd34;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;
  localparam logic signed [67:0] RND_HALF = 68'sd536870912;

  typedef struct packed {
    logic       tbl_we;
    logic       load;
    logic       pose_init;
    logic       cordic_start;
    logic       issue;
    logic [3:0] step;
  } fk_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } fk_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [35:0] atan_q30(input logic [4:0] k);
    logic signed [35:0] r;
    case (k)
      5'd0:  r = 36'sh03243F6A8;
      5'd1:  r = 36'sh01DAC6705;
      5'd2:  r = 36'sh00FADBAFC;
      5'd3:  r = 36'sh007F56EA6;
      5'd4:  r = 36'sh003FEAB76;
      5'd5:  r = 36'sh001FFD55B;
      5'd6:  r = 36'sh000FFFAAA;
      5'd7:  r = 36'sh0007FFF55;
      5'd8:  r = 36'sh0003FFFEA;
      5'd9:  r = 36'sh0001FFFFD;
      5'd10: r = 36'sh0000FFFFF;
      5'd11: r = 36'sh00007FFFF;
      5'd12: r = 36'sh00003FFFF;
      5'd13: r = 36'sh00001FFFF;
      5'd14: r = 36'sh00000FFFF;
      5'd15: r = 36'sh000007FFF;
      5'd16: r = 36'sh000003FFF;
      5'd17: r = 36'sh000001FFF;
      5'd18: r = 36'sh000000FFF;
      5'd19: r = 36'sh0000007FF;
      5'd20: r = 36'sh0000003FF;
      5'd21: r = 36'sh0000001FF;
      5'd22: r = 36'sh0000000FF;
      5'd23: r = 36'sh00000007F;
      5'd24: r = 36'sh00000003F;
      5'd25: r = 36'sh00000001F;
      5'd26: r = 36'sh00000000F;
      5'd27: r = 36'sh000000007;
      5'd28: r = 36'sh000000003;
      5'd29: r = 36'sh000000001;
      default: r = 36'sh000000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/mdhfk_cordic.sv]
// Iterative sine and cosine unit: four range reductions, one fold and thirty
// rotation steps, one per cycle. Depends on mdhfk_pkg.
`default_nettype none
module mdhfk_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [32:0] angle,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o,
  output logic                    done
);
  import mdhfk_pkg::*;

  logic signed [35:0] t_r, t_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic               flip_r, flip_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0]         kw;
  logic [4:0]         k;
  logic signed [33:0] dx, dy;

  always_comb begin
    t_nxt    = t_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    flip_nxt = flip_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    kw       = cnt_r - CORDIC_ITER0;
    k        = kw[4:0];
    dx       = y_r >>> k;
    dy       = x_r >>> k;
    if (start) begin
      t_nxt    = {angle[32], angle, 2'b00};
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      flip_nxt = 1'b0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r < CORDIC_FOLD) begin
        if (t_r > PI_Q30) begin
          t_nxt = t_r - TWO_PI_Q30;
        end else if (t_r < -PI_Q30) begin
          t_nxt = t_r + TWO_PI_Q30;
        end
      end else if (cnt_r == CORDIC_FOLD) begin
        if (t_r > HALF_PI_Q30) begin
          t_nxt    = t_r - PI_Q30;
          flip_nxt = 1'b1;
        end else if (t_r < -HALF_PI_Q30) begin
          t_nxt    = t_r + PI_Q30;
          flip_nxt = 1'b1;
        end
      end else begin
        if (t_r >= 36'sd0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          t_nxt = t_r - atan_q30(k);
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          t_nxt = t_r + atan_q30(k);
        end
      end
      if (cnt_r == CORDIC_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    t_r    <= t_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    flip_r <= flip_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;
  assign done  = done_r;

endmodule
`default_nettype wire

[rtl/mdhfk_datapath.sv]
// Datapath: geometry tables, two sine and cosine units, three rounding
// multipliers and the running pose. Depends on mdhfk_pkg and mdhfk_cordic.
`default_nettype none
module mdhfk_datapath #(
  parameter int MAX_JOINTS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mdhfk_pkg::fk_cmd_t       cmd,
  output mdhfk_pkg::fk_sts_t            sts,
  input  wire logic [2:0]               joint_sel,
  input  wire logic signed [31:0]       joint_value,
  input  wire logic signed [31:0]       link_length,
  input  wire logic signed [31:0]       link_twist,
  input  wire logic signed [31:0]       link_offset,
  input  wire logic signed [31:0]       angle_offset,
  input  wire logic                     is_prismatic,
  output logic signed [31:0]            rot [9],
  output logic signed [31:0]            pos [3]
);
  import mdhfk_pkg::*;

  localparam int IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic signed [31:0] len_tbl_r [MAX_JOINTS];
  logic signed [31:0] twist_tbl_r [MAX_JOINTS];
  logic signed [31:0] off_tbl_r [MAX_JOINTS];
  logic signed [31:0] ang_tbl_r [MAX_JOINTS];
  logic               pri_tbl_r [MAX_JOINTS];

  logic [4:0]         jx;
  logic [IW-1:0]      idx;
  logic signed [31:0] a_r, alpha_r, d_r, d_nxt;
  logic signed [32:0] theta_r, theta_nxt;
  logic signed [33:0] ct, st, ca, sa;
  logic               done_t, done_a;

  logic signed [33:0] lr3_r, lr4_r, lr6_r, lr7_r;
  logic signed [31:0] lp1_r, lp2_r;
  logic signed [33:0] ma [3];
  logic signed [33:0] mb [3];
  logic signed [37:0] p_r [3];
  logic signed [37:0] p_nxt [3];
  logic signed [67:0] prod;

  logic [3:0]         e, wb_e, wb_step_r;
  logic               wb_valid_r;
  logic [1:0]         ir, ic, wr, wc;
  logic signed [39:0] sum;
  logic signed [31:0] val;

  logic signed [31:0] rot_r [9];
  logic signed [31:0] rot_nxt [9];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] pos_nxt [3];
  logic signed [31:0] tmp_r [3];
  logic signed [31:0] tmp_nxt [3];

  assign jx  = {2'b00, joint_sel};
  assign idx = jx[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.tbl_we) begin
      len_tbl_r[idx]   <= link_length;
      twist_tbl_r[idx] <= link_twist;
      off_tbl_r[idx]   <= link_offset;
      ang_tbl_r[idx]   <= angle_offset;
      pri_tbl_r[idx]   <= is_prismatic;
    end
  end

  always_comb begin
    if (pri_tbl_r[idx]) begin
      d_nxt     = sat32(40'(off_tbl_r[idx]) + 40'(joint_value));
      theta_nxt = 33'(ang_tbl_r[idx]);
    end else begin
      d_nxt     = off_tbl_r[idx];
      theta_nxt = 33'(ang_tbl_r[idx]) + 33'(joint_value);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= len_tbl_r[idx];
      alpha_r <= twist_tbl_r[idx];
      d_r     <= d_nxt;
      theta_r <= theta_nxt;
    end
  end

  mdhfk_cordic u_cordic_theta (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cordic_start),
    .angle (theta_r),
    .cos_o (ct),
    .sin_o (st),
    .done  (done_t)
  );

  mdhfk_cordic u_cordic_alpha (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cordic_start),
    .angle (33'(alpha_r)),
    .cos_o (ca),
    .sin_o (sa),
    .done  (done_a)
  );

  assign sts.cordic_done = done_t & done_a;

  assign e  = cmd.step - STEP_POSE0;
  assign ir = e[3:2];
  assign ic = e[1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    if (cmd.step == STEP_LINK0) begin
      ma[0] = st; mb[0] = ca;
      ma[1] = ct; mb[1] = ca;
      ma[2] = st; mb[2] = sa;
    end else if (cmd.step == STEP_LINK1) begin
      ma[0] = ct;       mb[0] = sa;
      ma[1] = 34'(d_r); mb[1] = sa;
      ma[2] = 34'(d_r); mb[2] = ca;
    end else begin
      case (ir)
        2'd0: begin
          ma[0] = 34'(rot_r[0]); ma[1] = 34'(rot_r[1]); ma[2] = 34'(rot_r[2]);
        end
        2'd1: begin
          ma[0] = 34'(rot_r[3]); ma[1] = 34'(rot_r[4]); ma[2] = 34'(rot_r[5]);
        end
        2'd2: begin
          ma[0] = 34'(rot_r[6]); ma[1] = 34'(rot_r[7]); ma[2] = 34'(rot_r[8]);
        end
        default: begin
          ma[0] = '0; ma[1] = '0; ma[2] = '0;
        end
      endcase
      case (ic)
        2'd0: begin
          mb[0] = ct; mb[1] = lr3_r; mb[2] = lr6_r;
        end
        2'd1: begin
          mb[0] = -st; mb[1] = lr4_r; mb[2] = lr7_r;
        end
        2'd2: begin
          mb[0] = '0; mb[1] = -sa; mb[2] = ca;
        end
        default: begin
          mb[0] = 34'(a_r); mb[1] = 34'(lp1_r); mb[2] = 34'(lp2_r);
        end
      endcase
    end
  end

  always_comb begin
    prod = '0;
    for (int i = 0; i < 3; i++) begin
      prod     = ma[i] * mb[i] + RND_HALF;
      p_nxt[i] = prod[67:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else begin
      wb_valid_r <= cmd.issue;
    end
    wb_step_r <= cmd.step;
    for (int i = 0; i < 3; i++) begin
      p_r[i] <= p_nxt[i];
    end
  end

  assign wb_e = wb_step_r - STEP_POSE0;
  assign wr   = wb_e[3:2];
  assign wc   = wb_e[1:0];

  always_comb begin
    sum = 40'(p_r[0]) + 40'(p_r[1]) + 40'(p_r[2]);
    if (wc == 2'd3) begin
      case (wr)
        2'd0:    sum = sum + 40'(pos_r[0]);
        2'd1:    sum = sum + 40'(pos_r[1]);
        2'd2:    sum = sum + 40'(pos_r[2]);
        default: sum = sum;
      endcase
    end
    val = sat32(sum);
  end

  always_ff @(posedge clk) begin
    if (wb_valid_r && wb_step_r == STEP_LINK0) begin
      lr3_r <= p_r[0][33:0];
      lr4_r <= p_r[1][33:0];
      lr6_r <= p_r[2][33:0];
    end
    if (wb_valid_r && wb_step_r == STEP_LINK1) begin
      lr7_r <= p_r[0][33:0];
      lp1_r <= sat32(-40'(p_r[1]));
      lp2_r <= sat32(40'(p_r[2]));
    end
  end

  always_comb begin
    rot_nxt = rot_r;
    pos_nxt = pos_r;
    tmp_nxt = tmp_r;
    if (cmd.pose_init) begin
      for (int i = 0; i < 9; i++) begin
        rot_nxt[i] = (i % 4 == 0) ? Q30_ONE : '0;
      end
      for (int i = 0; i < 3; i++) begin
        pos_nxt[i] = '0;
      end
    end else if (wb_valid_r && wb_step_r >= STEP_POSE0) begin
      if (wc != 2'd3) begin
        tmp_nxt[wc] = val;
      end else begin
        case (wr)
          2'd0: begin
            pos_nxt[0] = val;
            rot_nxt[0] = tmp_r[0]; rot_nxt[1] = tmp_r[1]; rot_nxt[2] = tmp_r[2];
          end
          2'd1: begin
            pos_nxt[1] = val;
            rot_nxt[3] = tmp_r[0]; rot_nxt[4] = tmp_r[1]; rot_nxt[5] = tmp_r[2];
          end
          2'd2: begin
            pos_nxt[2] = val;
            rot_nxt[6] = tmp_r[0]; rot_nxt[7] = tmp_r[1]; rot_nxt[8] = tmp_r[2];
          end
          default: begin
            pos_nxt = pos_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        rot_r[i] <= (i % 4 == 0) ? Q30_ONE : '0;
      end
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      rot_r <= rot_nxt;
      pos_r <= pos_nxt;
    end
    tmp_r <= tmp_nxt;
  end

  assign rot = rot_r;
  assign pos = pos_r;

endmodule
`default_nettype wire

[rtl/mdhfk_ctrl.sv]
// Controller: command decode, joint count register and the sequencer that
// steps the datapath through one joint. Depends on mdhfk_pkg.
`default_nettype none
module mdhfk_ctrl #(
  parameter int MAX_JOINTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_cmd,
  input  wire logic [2:0]         in_joint_sel,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_data,
  output mdhfk_pkg::fk_cmd_t      cmd,
  input  wire mdhfk_pkg::fk_sts_t sts,
  output logic                    out_valid
);
  import mdhfk_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_CORD  = 6'b000100,
    S_MULT  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       emit_r, emit_nxt;
  logic [3:0] jcnt_r, jcnt_nxt;
  logic [4:0] jx, lastm1;
  logic       accept, idx_ok;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign jx        = {2'b00, in_joint_sel};
  assign idx_ok    = jx < 5'(MAX_JOINTS);

  always_comb begin
    if (jcnt_r == 4'd0) begin
      lastm1 = 5'd0;
    end else if (5'(jcnt_r) > 5'(MAX_JOINTS)) begin
      lastm1 = 5'(MAX_JOINTS - 1);
    end else begin
      lastm1 = 5'(jcnt_r) - 5'd1;
    end
  end

  always_comb begin
    cmd.tbl_we       = accept && (in_cmd == CMD_GEOM) && idx_ok;
    cmd.load         = accept && (in_cmd == CMD_JOINT) && idx_ok;
    cmd.pose_init    = cmd.load && (in_joint_sel == 3'd0);
    cmd.cordic_start = (state_r == S_START);
    cmd.issue        = (state_r == S_MULT) && (cnt_r != STEP_BUBBLE);
    cmd.step         = cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    emit_nxt  = emit_r;
    jcnt_nxt  = jcnt_r;
    if (cfg_valid && cfg_ready) begin
      jcnt_nxt = cfg_data;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_START;
          emit_nxt  = (jx == lastm1);
        end
      end
      S_START: begin
        state_nxt = S_CORD;
      end
      S_CORD: begin
        if (sts.cordic_done) begin
          state_nxt = S_MULT;
          cnt_nxt   = STEP_LINK0;
        end
      end
      S_MULT: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == STEP_LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = emit_r ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      jcnt_r  <= 4'd6;
      emit_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      jcnt_r  <= jcnt_nxt;
      emit_r  <= emit_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid = (state_r == S_OUT);

endmodule
`default_nettype wire

[rtl/mdh_forward_kinematics_unit.sv]
// Top level of the modified-DH forward kinematics block.
// Depends on mdhfk_pkg, mdhfk_ctrl and mdhfk_datapath.
//
// An item is taken when start is high and busy is low. A geometry item
// (in_cmd 0) writes one joint's row of the table in that cycle and leaves
// busy low. A joint item (in_cmd 1) raises busy while the block starts the
// two sine and cosine units, lets them run side by side (four reductions,
// fold, thirty rotation steps and the done flag), issues to three rounding
// multipliers that build the link transform and then one element of the new
// pose per cycle, and writes back. When the joint is the last of the
// configured chain, out_valid is high for one more busy cycle at the end,
// with the rotation and position on the out_ ports. A new item can be taken
// only once busy is low again. The receiver has no way to stall.
// Joint items with an index at or above MAX_JOINTS are dropped.
// The joint count is written through cfg_valid and cfg_ready while idle.
// Synchronous reset sets the count to six and the pose to identity; the
// geometry table is not cleared.
`default_nettype none
module mdh_forward_kinematics_unit #(
  parameter int MAX_JOINTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_cmd,
  input  wire logic [2:0]         in_joint_sel,
  input  wire logic signed [31:0] in_joint_value,
  input  wire logic signed [31:0] in_link_length,
  input  wire logic signed [31:0] in_link_twist,
  input  wire logic signed [31:0] in_link_offset,
  input  wire logic signed [31:0] in_angle_offset,
  input  wire logic               in_is_prismatic,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_data,
  output logic                    out_valid,
  output logic signed [31:0]      out_r00,
  output logic signed [31:0]      out_r01,
  output logic signed [31:0]      out_r02,
  output logic signed [31:0]      out_r10,
  output logic signed [31:0]      out_r11,
  output logic signed [31:0]      out_r12,
  output logic signed [31:0]      out_r20,
  output logic signed [31:0]      out_r21,
  output logic signed [31:0]      out_r22,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z
);
  import mdhfk_pkg::*;

  fk_cmd_t            cmd;
  fk_sts_t            sts;
  logic signed [31:0] rot [9];
  logic signed [31:0] pos [3];

  mdhfk_ctrl #(.MAX_JOINTS(MAX_JOINTS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_joint_sel (in_joint_sel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid)
  );

  mdhfk_datapath #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .joint_sel    (in_joint_sel),
    .joint_value  (in_joint_value),
    .link_length  (in_link_length),
    .link_twist   (in_link_twist),
    .link_offset  (in_link_offset),
    .angle_offset (in_angle_offset),
    .is_prismatic (in_is_prismatic),
    .rot          (rot),
    .pos          (pos)
  );

  assign out_r00   = rot[0];
  assign out_r01   = rot[1];
  assign out_r02   = rot[2];
  assign out_r10   = rot[3];
  assign out_r11   = rot[4];
  assign out_r12   = rot[5];
  assign out_r20   = rot[6];
  assign out_r21   = rot[7];
  assign out_r22   = rot[8];
  assign out_pos_x = pos[0];
  assign out_pos_y = pos[1];
  assign out_pos_z = pos[2];

endmodule
`default_nettype wire

[rtl/mdhfk_checker.sv]
// Port-level checks on the forward kinematics block and the bind that
// attaches them to mdh_forward_kinematics_unit. Depends on nothing else.
`default_nettype none
module mdhfk_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_cmd,
  input wire logic out_valid
);

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat shown while not busy");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat lasted more than one cycle");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after its result beat");

  a_geometry_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_cmd) |=> !busy)
    else $error("geometry beat made the block busy");

endmodule

bind mdh_forward_kinematics_unit mdhfk_checker u_mdhfk_checker (.*);
`default_nettype wire

[tb/tb.sv]
// Testbench for mdh_forward_kinematics_unit: drives geometry and joint beats,
// predicts each emitted pose with an in-bench fixed-point model and checks it.
// Depends on mdhfk_pkg and the RTL of the block only.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mdhfk_pkg::*;

  localparam int NUM_JOINTS = 8;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint PI_V = 64'sd3373259426;
  localparam longint TWO_PI_V = 64'sd6746518852;
  localparam longint HALF_PI_V = 64'sd1686629713;
  localparam longint GAIN_V = 64'sd652032874;
  localparam longint ONE_V = 64'sd1073741824;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = CMD_GEOM;
  logic [2:0] in_joint_sel = '0;
  logic signed [31:0] in_joint_value = '0;
  logic signed [31:0] in_link_length = '0;
  logic signed [31:0] in_link_twist = '0;
  logic signed [31:0] in_link_offset = '0;
  logic signed [31:0] in_angle_offset = '0;
  logic in_is_prismatic = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic out_valid;
  logic signed [31:0] out_r00, out_r01, out_r02, out_r10, out_r11, out_r12;
  logic signed [31:0] out_r20, out_r21, out_r22, out_pos_x, out_pos_y, out_pos_z;

  mdh_forward_kinematics_unit #(.MAX_JOINTS(NUM_JOINTS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_joint_sel(in_joint_sel), .in_joint_value(in_joint_value),
    .in_link_length(in_link_length), .in_link_twist(in_link_twist),
    .in_link_offset(in_link_offset), .in_angle_offset(in_angle_offset),
    .in_is_prismatic(in_is_prismatic),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_r00(out_r00), .out_r01(out_r01), .out_r02(out_r02),
    .out_r10(out_r10), .out_r11(out_r11), .out_r12(out_r12),
    .out_r20(out_r20), .out_r21(out_r21), .out_r22(out_r22),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longint geo_length [NUM_JOINTS];
  longint geo_twist [NUM_JOINTS];
  longint geo_offset [NUM_JOINTS];
  longint geo_angle [NUM_JOINTS];
  bit geo_prismatic [NUM_JOINTS];
  longint pose_rot [9];
  longint pose_pos [3];
  logic [3:0] joint_count_reg = 4'd6;
  logic [383:0] expected_poses [$];
  int err_count = 0;
  longint cycle_count = 0;
  bit gaps_on = 1'b1;

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint arctan_step(input int k);
    logic signed [35:0] v;
    v = atan_q30(k[4:0]);
    return longint'(v);
  endfunction

  task automatic cordic_sincos(input longint theta, output longint c, output longint s);
    longint t, x, y, dx, dy;
    bit flip;
    t = theta * 4;
    x = GAIN_V;
    y = 0;
    flip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (t > PI_V) t -= TWO_PI_V;
      else if (t < -PI_V) t += TWO_PI_V;
    end
    if (t > HALF_PI_V) begin
      t -= PI_V;
      flip = 1'b1;
    end else if (t < -HALF_PI_V) begin
      t += PI_V;
      flip = 1'b1;
    end
    for (int k = 0; k < 30; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (t >= 0) begin
        x -= dx; y += dy; t -= arctan_step(k);
      end else begin
        x += dx; y -= dy; t += arctan_step(k);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic pose_reset();
    for (int i = 0; i < 9; i++) pose_rot[i] = (i % 4 == 0) ? ONE_V : 0;
    for (int i = 0; i < 3; i++) pose_pos[i] = 0;
  endtask

  task automatic pose_apply(input int j, input longint value);
    longint ct, st, ca, sa, d, theta;
    longint lr [9];
    longint lp [3];
    longint nr [9];
    longint np [3];
    d = geo_offset[j];
    theta = geo_angle[j];
    if (geo_prismatic[j]) d = sat_word(d + value);
    else theta += value;
    cordic_sincos(theta, ct, st);
    cordic_sincos(geo_twist[j], ca, sa);
    lr[0] = ct; lr[1] = -st; lr[2] = 0;
    lr[3] = round_mul(st, ca); lr[4] = round_mul(ct, ca); lr[5] = -sa;
    lr[6] = round_mul(st, sa); lr[7] = round_mul(ct, sa); lr[8] = ca;
    lp[0] = geo_length[j];
    lp[1] = sat_word(-round_mul(d, sa));
    lp[2] = sat_word(round_mul(d, ca));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++)
        nr[r*3+c] = sat_word(round_mul(pose_rot[r*3], lr[c]) +
                             round_mul(pose_rot[r*3+1], lr[3+c]) +
                             round_mul(pose_rot[r*3+2], lr[6+c]));
      np[r] = sat_word(pose_pos[r] + round_mul(pose_rot[r*3], lp[0]) +
                       round_mul(pose_rot[r*3+1], lp[1]) +
                       round_mul(pose_rot[r*3+2], lp[2]));
    end
    for (int i = 0; i < 9; i++) pose_rot[i] = nr[i];
    for (int i = 0; i < 3; i++) pose_pos[i] = np[i];
  endtask

  task automatic predict_beat(input logic cmd, input logic [2:0] idx,
                              input logic signed [31:0] val, input logic signed [31:0] a,
                              input logic signed [31:0] alpha, input logic signed [31:0] d,
                              input logic signed [31:0] th, input logic pris);
    int last;
    logic [383:0] packed_pose;
    if (cmd == CMD_GEOM) begin
      geo_length[idx] = a;
      geo_twist[idx] = alpha;
      geo_offset[idx] = d;
      geo_angle[idx] = th;
      geo_prismatic[idx] = pris;
      return;
    end
    if (idx == 0) pose_reset();
    pose_apply(int'(idx), longint'(val));
    last = (joint_count_reg == 0) ? 1 : (joint_count_reg > NUM_JOINTS) ? NUM_JOINTS
           : int'(joint_count_reg);
    if (int'(idx) != last - 1) return;
    for (int i = 0; i < 9; i++) packed_pose[i*32 +: 32] = pose_rot[i][31:0];
    for (int i = 0; i < 3; i++) packed_pose[(9+i)*32 +: 32] = pose_pos[i][31:0];
    expected_poses.push_back(packed_pose);
  endtask

  task automatic send_beat(input logic cmd, input logic [2:0] idx,
                           input logic signed [31:0] val, input logic signed [31:0] a,
                           input logic signed [31:0] alpha, input logic signed [31:0] d,
                           input logic signed [31:0] th, input logic pris);
    start <= 1'b1;
    in_cmd <= cmd;
    in_joint_sel <= idx;
    in_joint_value <= val;
    in_link_length <= a;
    in_link_twist <= alpha;
    in_link_offset <= d;
    in_angle_offset <= th;
    in_is_prismatic <= pris;
    do @(posedge clk); while (busy);
    predict_beat(cmd, idx, val, a, alpha, d, th, pris);
    if (gaps_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh20000000;
    endcase
  endfunction

  task automatic send_geometry(input logic [2:0] idx);
    send_beat(CMD_GEOM, idx, rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), 1'($urandom_range(1)));
  endtask

  task automatic send_joint(input logic [2:0] idx);
    send_beat(CMD_JOINT, idx, rand_word(), $urandom, $urandom, $urandom, $urandom,
              1'($urandom_range(1)));
  endtask

  task automatic drain_and_write_count(input logic [3:0] value);
    start <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    joint_count_reg = value;
  endtask

  always @(posedge clk) begin
    logic [383:0] want;
    logic signed [31:0] got [12];
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
    if (rst_n && out_valid) begin
      got = '{out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
              out_r20, out_r21, out_r22, out_pos_x, out_pos_y, out_pos_z};
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected pose beat", $realtime);
        err_count++;
      end else begin
        want = expected_poses.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (got[i] !== want[i*32 +: 32]) begin
            $display("%0t: field %0d expected %h actual %h", $realtime, i,
                     want[i*32 +: 32], got[i]);
            err_count++;
          end
        end
      end
    end
  end

  task automatic test_geometry_extremes();
    send_beat(CMD_GEOM, 0, 0, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_GEOM, 1, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 1'b1);
    send_beat(CMD_GEOM, 2, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 1'b0);
    send_beat(CMD_GEOM, 3, 0, 32'sh01000000, 32'sh1921FB54, 32'sh00800000, 0, 1'b1);
    for (int j = 4; j < NUM_JOINTS; j++) send_geometry(3'(j));
  endtask

  task automatic test_chain_extremes();
    send_beat(CMD_JOINT, 0, 32'sh7FFFFFFF, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 1, 32'sh7FFFFFFF, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 2, 32'sh80000000, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 3, 32'sh80000000, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 4, 0, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 5, 32'sh12345678, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 7, 32'sh0, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 3, 32'sh1, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_JOINT, 5, 32'shFFFFFFFF, 0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_count_settings();
    drain_and_write_count(4'd0);
    send_joint(0);
    send_joint(0);
    drain_and_write_count(4'd15);
    for (int j = 0; j < NUM_JOINTS; j++) send_joint(3'(j));
    drain_and_write_count(4'd1);
    send_joint(0);
    drain_and_write_count(4'd8);
    for (int j = 0; j < NUM_JOINTS; j++) send_joint(3'(j));
  endtask

  task automatic test_random_chains();
    int sent;
    int n;
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      drain_and_write_count(4'($urandom_range(15)));
      gaps_on = (phase != 3);
      for (int k = 0; k < 200; k++) begin
        case ($urandom_range(19))
          0: send_geometry(3'($urandom_range(7)));
          1, 2: send_joint(3'($urandom_range(7)));
          default: begin
            n = (joint_count_reg == 0) ? 1 : (joint_count_reg > NUM_JOINTS) ?
                NUM_JOINTS : int'(joint_count_reg);
            for (int j = 0; j < n; j++) send_joint(3'(j));
            k += n - 1;
          end
        endcase
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pose_reset();
    test_geometry_extremes();
    test_chain_extremes();
    test_count_settings();
    test_random_chains();
    start <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
rtl/mdhfk_pkg.sv
rtl/mdhfk_cordic.sv
rtl/mdhfk_datapath.sv
rtl/mdhfk_ctrl.sv
rtl/mdh_forward_kinematics_unit.sv
rtl/mdhfk_checker.sv
tb/tb.sv
